FILE: src/salru_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salru_pkg
// Shared types and constants of the set-associative LRU write-back cache.
// ----------------------------------------------------------------------------
package salru_pkg;

  localparam int ADDR_W = 48;
  localparam int CFG_W  = 4;
  localparam int OB_MAX_I = 12;

  localparam logic [CFG_W-1:0] OB_MIN   = 4'd2;
  localparam logic [CFG_W-1:0] OB_MAX   = 4'd12;
  localparam logic [CFG_W-1:0] OB_RESET = 4'd6;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  // Control from the sequencer to the way compare unit
  typedef struct packed {
    logic en;
    logic first;
  } scan_ctl_t;

  function automatic logic [CFG_W-1:0] clamp_ob(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (v < OB_MIN) r = OB_MIN;
    if (v > OB_MAX) r = OB_MAX;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/salru_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salru_req_if
// Access channel: byte address and read/write mode.
// ----------------------------------------------------------------------------
interface salru_req_if;
  import salru_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic              mode;

  modport source (output valid, output address, output mode, input ready);
  modport sink   (input valid, input address, input mode, output ready);
endinterface
`default_nettype wire

FILE: src/salru_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salru_rsp_if
// Result channel: hit flag and writeback request of the victim line.
// ----------------------------------------------------------------------------
interface salru_rsp_if;
  import salru_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit;
  logic              writeback;
  logic [ADDR_W-1:0] writeback_address;

  modport source (output valid, output hit, output writeback, output writeback_address,
                  input ready);
  modport sink   (input valid, input hit, input writeback, input writeback_address,
                  output ready);
endinterface
`default_nettype wire

FILE: src/set_assoc_lru_writeback_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache
// Tag and state side of a set-associative write-back cache, true LRU.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one access (address, mode); rsp returns one result per
//   access: hit, writeback and the line-aligned victim address.
//   cfg_wr_en/cfg_wr_data write the line offset width; write it only while
//   no access is in flight.
//   Each set is one row of a single RAM holding tag, valid, dirty and age of
//   all ways. An access reads its row in the accept cycle, then a shared
//   compare unit visits one way per cycle, and a write state then writes the
//   updated row and loads the result register. req.ready is high only in
//   the idle state, so a new access is taken only after the previous one
//   has written its row.
//   The result register lets a new item enter while a result waits; the
//   row write holds if the previous result has still not been taken.
//   After reset the block sweeps the RAM, one set per cycle, with
//   req.ready low; configuration writes are taken during the sweep.
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache #(
  parameter int SET_IDX_W = 8,
  parameter int WAYS      = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [salru_pkg::CFG_W-1:0] cfg_wr_data,
  salru_req_if.sink                        req,
  salru_rsp_if.source                      rsp
);
  import salru_pkg::*;

  localparam int SETS   = 1 << SET_IDX_W;
  localparam int TAG_W  = ADDR_W - 2 - SET_IDX_W;
  localparam int WAY_W  = $clog2(WAYS);
  localparam int ENT_W  = TAG_W + 2 + WAY_W;
  localparam int ROW_W  = WAYS * ENT_W;
  localparam int WB_W   = ADDR_W + OB_MAX_I;
  localparam int VLD_B  = WAY_W + 1;
  localparam int DRT_B  = WAY_W;

  state_t                    state;
  state_t                    state_next;
  logic [CFG_W-1:0]          ob_reg;
  logic [CFG_W-1:0]          ob_eff;
  logic [SET_IDX_W-1:0]      clr_idx;
  logic [WAY_W-1:0]          way_idx;
  logic [TAG_W-1:0]          cur_tag;
  logic [SET_IDX_W-1:0]      cur_set;
  logic                      cur_mode;

  logic                      out_valid;
  logic                      out_hit;
  logic                      out_wb;
  logic [ADDR_W-1:0]         out_wba;

  logic                      ram_we;
  logic                      ram_re;
  logic [SET_IDX_W-1:0]      ram_waddr;
  logic [ROW_W-1:0]          ram_wdata;
  logic [SET_IDX_W-1:0]      ram_raddr;
  logic [ROW_W-1:0]          ram_rdata;

  logic [WAYS-1:0][ENT_W-1:0] row_q;
  logic [WAYS-1:0][ENT_W-1:0] row_upd;
  logic [WAYS-1:0][ENT_W-1:0] row_init;
  logic [ENT_W-1:0]           scan_ent;
  logic [ENT_W-1:0]           sel_ent;
  logic [ENT_W-1:0]           vic_ent;

  scan_ctl_t                 scan_ctl;
  logic                      hit_found;
  logic [WAY_W-1:0]          hit_way;
  logic [WAY_W-1:0]          vic_way;
  logic [WAY_W-1:0]          sel_way;

  logic                      accept;
  logic                      out_free;
  logic                      load_out;
  logic                      last_way;
  logic                      last_set;
  logic [5:0]                tag_sh;
  logic [ADDR_W-1:0]         addr_tag;
  logic [ADDR_W-1:0]         addr_set;
  logic                      vic_wb;
  logic [WB_W-1:0]           wb_wide;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_reg <= OB_RESET;
    end else if (cfg_wr_en) begin
      ob_reg <= cfg_wr_data;
    end
  end

  assign ob_eff = clamp_ob(ob_reg);

  // --------------------------------------------------------------------------
  // Address split
  // --------------------------------------------------------------------------
  assign tag_sh   = 6'(ob_eff) + 6'(SET_IDX_W);
  assign addr_tag = req.address >> tag_sh;
  assign addr_set = req.address >> ob_eff;

  // --------------------------------------------------------------------------
  // Set RAM: one row per set
  // --------------------------------------------------------------------------
  salru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign row_q     = ram_rdata;
  assign ram_raddr = addr_set[SET_IDX_W-1:0];

  // --------------------------------------------------------------------------
  // Shared way compare unit
  // --------------------------------------------------------------------------
  assign scan_ent = row_q[way_idx];

  salru_way_cmp #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W)
  ) u_cmp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (scan_ctl),
    .idx       (way_idx),
    .ent_valid (scan_ent[VLD_B]),
    .ent_tag   (scan_ent[ENT_W-1 -: TAG_W]),
    .ent_age   (scan_ent[WAY_W-1:0]),
    .cur_tag   (cur_tag),
    .hit_found (hit_found),
    .hit_way   (hit_way),
    .vic_way   (vic_way)
  );

  // --------------------------------------------------------------------------
  // Row update and result
  // --------------------------------------------------------------------------
  assign sel_way = hit_found ? hit_way : vic_way;
  assign sel_ent = row_q[sel_way];
  assign vic_ent = row_q[vic_way];
  assign vic_wb  = !hit_found && vic_ent[VLD_B] && vic_ent[DRT_B];
  assign wb_wide = WB_W'({vic_ent[ENT_W-1 -: TAG_W], cur_set}) << ob_eff;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      row_init[w] = {{TAG_W{1'b0}}, 1'b0, 1'b0, WAY_W'(w)};
      row_upd[w]  = row_q[w];
      // ways younger than the touched one age by one
      if (row_q[w][WAY_W-1:0] < sel_ent[WAY_W-1:0]) begin
        row_upd[w][WAY_W-1:0] = row_q[w][WAY_W-1:0] + WAY_W'(1);
      end
    end
    row_upd[sel_way][WAY_W-1:0] = '0;
    if (hit_found) begin
      row_upd[sel_way][DRT_B] = sel_ent[DRT_B] | cur_mode;
    end else begin
      row_upd[sel_way][ENT_W-1 -: TAG_W] = cur_tag;
      row_upd[sel_way][VLD_B]            = 1'b1;
      row_upd[sel_way][DRT_B]            = cur_mode;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign last_way = way_idx == WAY_W'(WAYS - 1);
  assign last_set = clr_idx == '1;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (last_set) state_next = ST_IDLE;
      ST_IDLE:  if (req.valid) state_next = ST_SCAN;
      ST_SCAN:  if (last_way) state_next = ST_WRITE;
      ST_WRITE: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    req.ready      = 1'b0;
    ram_re         = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = cur_set;
    ram_wdata      = row_upd;
    scan_ctl.en    = 1'b0;
    scan_ctl.first = 1'b0;
    load_out       = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = row_init;
      end
      ST_IDLE: begin
        req.ready = 1'b1;
        ram_re    = req.valid;
      end
      ST_SCAN: begin
        scan_ctl.en    = 1'b1;
        scan_ctl.first = way_idx == '0;
      end
      ST_WRITE: begin
        ram_we   = out_free;
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      way_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + SET_IDX_W'(1);
      end
      if (state == ST_SCAN) begin
        way_idx <= last_way ? '0 : way_idx + WAY_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_tag  <= addr_tag[TAG_W-1:0];
      cur_set  <= addr_set[SET_IDX_W-1:0];
      cur_mode <= req.mode;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_hit <= hit_found;
      out_wb  <= vic_wb;
      out_wba <= vic_wb ? wb_wide[ADDR_W-1:0] : '0;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.hit               = out_hit;
  assign rsp.writeback         = out_wb;
  assign rsp.writeback_address = out_wba;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("row write and row read in the same cycle");

  a_hit_no_wb: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_hit && out_wb))
    else $error("result reports both hit and writeback");

  a_wba_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_wb) |-> (out_wba == '0))
    else $error("writeback address set without writeback");

  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && hit_found) |-> sel_ent[VLD_B])
    else $error("hit on an invalid way");

endmodule
`default_nettype wire

FILE: src/salru_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salru_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: src/salru_way_cmp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// salru_way_cmp
// Shared compare unit: looks at one way per cycle, keeps the youngest
// matching way and the oldest way of the set.
// ----------------------------------------------------------------------------
module salru_way_cmp #(
  parameter int WAYS  = 4,
  parameter int TAG_W = 38
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire salru_pkg::scan_ctl_t        ctl,
  input  wire logic [$clog2(WAYS)-1:0]     idx,
  input  wire logic                        ent_valid,
  input  wire logic [TAG_W-1:0]            ent_tag,
  input  wire logic [$clog2(WAYS)-1:0]     ent_age,
  input  wire logic [TAG_W-1:0]            cur_tag,
  output logic                             hit_found,
  output logic [$clog2(WAYS)-1:0]          hit_way,
  output logic [$clog2(WAYS)-1:0]          vic_way
);
  import salru_pkg::*;

  localparam int WAY_W = $clog2(WAYS);

  logic [WAY_W-1:0] hit_age;
  logic [WAY_W-1:0] vic_age;
  logic             prior_found;
  logic [WAY_W-1:0] prior_vage;
  logic             take_hit;
  logic             take_vic;

  always_comb begin
    prior_found = ctl.first ? 1'b0 : hit_found;
    prior_vage  = ctl.first ? '0 : vic_age;
    take_hit    = ent_valid && (ent_tag == cur_tag) && (!prior_found || ent_age < hit_age);
    // ties go to the later way
    take_vic    = ent_age >= prior_vage;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_found <= 1'b0;
    end else if (ctl.en) begin
      hit_found <= prior_found || take_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (take_hit) begin
        hit_age <= ent_age;
        hit_way <= idx;
      end
      if (take_vic) begin
        vic_age <= ent_age;
        vic_way <= idx;
      end
    end
  end

endmodule
`default_nettype wire
